### src/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types, codes and helpers for the swap slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

	// free map is stored as 32-bit words
	localparam int WORD_BITS = 32;
	localparam int OFS_BITS  = 5;

	// request opcodes; the remaining code is a no-op
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RELEASE = 2'd2
	} opcode_t;

	// request beat
	typedef struct packed {
		logic [1:0]  opcode;
		logic [11:0] block;
		logic [5:0]  env_index;
		logic [63:0] sharer_mask;
	} req_t;

	// response beat
	typedef struct packed {
		logic [11:0] alloc_block;
		logic        out_of_space;
		logic        block_freed;
	} rsp_t;

	// result of searching one free-map word
	typedef struct packed {
		logic                found;
		logic [OFS_BITS-1:0] bit_idx;
	} find_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_TAKE,
		ST_FETCH,
		ST_UPDATE,
		ST_RESP
	} state_t;

	// index of the lowest set bit (0 when none is set)
	function automatic logic [OFS_BITS-1:0] first_set(input logic [WORD_BITS-1:0] w);
		logic [OFS_BITS-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = OFS_BITS'(i);
			end
		end
		return idx;
	endfunction

endpackage

### src/swap_slot_allocator.sv
// ----------------------------------------------------------------------------
// swap_slot_allocator
// Next-fit swap block allocator with a per-block sharer mask store.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | beat
//  req     | in  | req_valid/req_stall | opcode, block, env_index, sharer_mask
//  rsp     | out | rsp_valid/rsp_stall | alloc_block, out_of_space, block_freed
//
//  One request is in work at a time. Free and release of an in-range block
//  read the free-map word in fetch and write back in update; allocate scans
//  one free-map word read per cycle, then takes the hit; other requests
//  go straight to the response state. After reset a clearing pass sets the
//  free map and zeroes the sharer store; req_stall stays high during it.
//  A new request is taken while the previous response still waits on
//  rsp_stall; a stalled response holds the sequencer in its last state.
//  NUM_BLOCKS must be a multiple of 32.
// ----------------------------------------------------------------------------
module swap_slot_allocator #(
	parameter int NUM_BLOCKS  = 4096,
	parameter int MAX_SHARERS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ssa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ssa_pkg::rsp_t rsp
);
	import ssa_pkg::*;

	localparam int WORDS = NUM_BLOCKS / WORD_BITS;
	localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW    = $clog2(NUM_BLOCKS);
	localparam int CW    = $clog2(WORDS + 2);
	localparam int SW    = MAX_SHARERS;

	// sequencer
	state_t state_q, state_d;

	// captured request
	logic [1:0]    op_q;
	logic [BW-1:0] blk_q;
	logic [5:0]    env_q;
	logic [SW-1:0] mask_q;

	logic [BW-1:0] clr_q;
	logic [BW-1:0] cursor_q;

	// scan issue side and check side
	logic [WAW-1:0] scan_word_q;
	logic [CW-1:0]  scan_cnt_q;
	logic           scan_issue;
	logic           chk_v_s1, chk_first_s1, chk_last_s1;
	logic [WAW-1:0] chk_word_s1;

	// hit captured for write-back
	logic [WAW-1:0]       fnd_word_q;
	logic [OFS_BITS-1:0]  fnd_bit_q;
	logic [WORD_BITS-1:0] fnd_data_q;
	logic [BW-1:0]        fnd_blk;

	rsp_t res_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic    req_fire;
	logic    rsp_load;
	logic    blk_in_range;
	logic    env_in_range;
	logic [SW-1:0] rel_mask;
	find_t   find;

	// memory ports
	logic                 fm_we, sh_we;
	logic [WAW-1:0]       fm_waddr, fm_raddr;
	logic [WORD_BITS-1:0] fm_wdata, fm_rdata;
	logic [BW-1:0]        sh_waddr;
	logic [SW-1:0]        sh_wdata, sh_rdata;

	assign req_stall = (state_q != ST_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign blk_in_range = (32'(req.block) < NUM_BLOCKS);
	assign env_in_range = (32'(env_q) < MAX_SHARERS);
	assign scan_issue   = (32'(scan_cnt_q) <= WORDS);
	assign fnd_blk      = BW'({fnd_word_q, fnd_bit_q});

	// release clears one sharer bit of the stored mask when env_index is in range
	assign rel_mask = env_in_range ? (sh_rdata & ~(SW'(1) << env_q)) : sh_rdata;

	// free map: one bit per block, 32 blocks per word
	ssa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORDS)
	) u_free_map (
		.clk  (clk),
		.we   (fm_we),
		.waddr(fm_waddr),
		.wdata(fm_wdata),
		.raddr(fm_raddr),
		.rdata(fm_rdata)
	);

	// sharer masks, one entry per block
	ssa_ram #(
		.WIDTH(SW),
		.DEPTH(NUM_BLOCKS)
	) u_sharer_store (
		.clk  (clk),
		.we   (sh_we),
		.waddr(sh_waddr),
		.wdata(sh_wdata),
		.raddr(blk_q),
		.rdata(sh_rdata)
	);

	// search of the word returned by the free map
	ssa_word_find u_find (
		.word (fm_rdata),
		.ofs  (cursor_q[OFS_BITS-1:0]),
		.first(chk_first_s1),
		.last (chk_last_s1),
		.res  (find)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (32'(clr_q) == NUM_BLOCKS - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_fire) begin
					if (req.opcode == OP_ALLOC) begin
						state_d = ST_SCAN;
					end else if ((req.opcode == OP_FREE || req.opcode == OP_RELEASE)
					             && blk_in_range) begin
						state_d = ST_FETCH;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SCAN: begin
				if (chk_v_s1 && find.found) begin
					state_d = ST_TAKE;
				end else if (chk_v_s1 && chk_last_s1) begin
					state_d = ST_RESP;
				end
			end
			ST_TAKE:   state_d = ST_RESP;
			ST_FETCH:  state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_RESP;
			ST_RESP: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		fm_we    = 1'b0;
		fm_waddr = WAW'(blk_q >> OFS_BITS);
		fm_wdata = fm_rdata | (WORD_BITS'(1) << blk_q[OFS_BITS-1:0]);
		fm_raddr = scan_word_q;
		sh_we    = 1'b0;
		sh_waddr = blk_q;
		sh_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				// one sharer entry per cycle; a free-map word when the low offset bits of clr_q are zero
				sh_we    = 1'b1;
				sh_waddr = clr_q;
				fm_we    = (clr_q[OFS_BITS-1:0] == '0);
				fm_waddr = WAW'(clr_q >> OFS_BITS);
				fm_wdata = '1;
			end
			ST_FETCH: begin
				fm_raddr = WAW'(blk_q >> OFS_BITS);
			end
			ST_UPDATE: begin
				sh_we = 1'b1;
				if (op_q == OP_FREE) begin
					fm_we = 1'b1;
				end else begin
					sh_wdata = rel_mask;
					fm_we    = (rel_mask == '0);
				end
			end
			ST_TAKE: begin
				fm_we    = 1'b1;
				fm_waddr = fnd_word_q;
				fm_wdata = fnd_data_q & ~(WORD_BITS'(1) << fnd_bit_q);
				sh_we    = 1'b1;
				sh_waddr = fnd_blk;
				sh_wdata = mask_q;
			end
			ST_IDLE, ST_SCAN, ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cursor_q    <= '0;
			chk_v_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_TAKE) begin
				cursor_q <= fnd_blk;
			end
			chk_v_s1 <= (state_q == ST_SCAN) && scan_issue;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request capture, scan pointers and result payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q        <= req.opcode;
			blk_q       <= BW'(req.block);
			env_q       <= req.env_index;
			mask_q      <= SW'(req.sharer_mask);
			res_q       <= '0;
			scan_word_q <= WAW'(cursor_q >> OFS_BITS);
			scan_cnt_q  <= '0;
		end
		if (state_q == ST_SCAN && scan_issue) begin
			chk_word_s1  <= scan_word_q;
			chk_first_s1 <= (scan_cnt_q == '0);
			chk_last_s1  <= (32'(scan_cnt_q) == WORDS);
			scan_cnt_q   <= scan_cnt_q + 1'b1;
			if (32'(scan_word_q) == WORDS - 1) begin
				scan_word_q <= '0;
			end else begin
				scan_word_q <= scan_word_q + 1'b1;
			end
		end
		if (state_q == ST_SCAN && chk_v_s1) begin
			if (find.found) begin
				fnd_word_q <= chk_word_s1;
				fnd_bit_q  <= find.bit_idx;
				fnd_data_q <= fm_rdata;
			end else if (chk_last_s1) begin
				res_q.out_of_space <= 1'b1;
			end
		end
		if (state_q == ST_TAKE) begin
			res_q.alloc_block <= 12'(fnd_blk);
		end
		if (state_q == ST_UPDATE) begin
			res_q.block_freed <= (op_q == OP_FREE) || (rel_mask == '0);
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

endmodule

### src/ssa_ram.sv
// ----------------------------------------------------------------------------
// ssa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ssa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### src/ssa_word_find.sv
// ----------------------------------------------------------------------------
// ssa_word_find
// Finds the lowest free block in one free-map word, limited to the part of
// the word that the current scan pass covers.
// ----------------------------------------------------------------------------
module ssa_word_find (
	input  logic [ssa_pkg::WORD_BITS-1:0] word,
	input  logic [ssa_pkg::OFS_BITS-1:0]  ofs,
	input  logic                          first,
	input  logic                          last,
	output ssa_pkg::find_t                res
);
	import ssa_pkg::*;

	logic [WORD_BITS-1:0] win;
	logic [WORD_BITS-1:0] hits;

	// first pass starts at the cursor bit; the wrap pass stops just below it
	always_comb begin
		win = '1;
		if (first) begin
			win = win & ({WORD_BITS{1'b1}} << ofs);
		end
		if (last) begin
			win = win & ~({WORD_BITS{1'b1}} << ofs);
		end
		hits = word & win;
	end

	assign res.found   = |hits;
	assign res.bit_idx = first_set(hits);

endmodule
